// File: rtl/tdc_tot_hit_pairing_coincidence_unit_defines.svh
// assertion macros for the tot hit pairing unit
`ifndef TDC_TOT_HIT_PAIRING_COINCIDENCE_UNIT_DEFINES_SVH
`define TDC_TOT_HIT_PAIRING_COINCIDENCE_UNIT_DEFINES_SVH
// implication checked on every clock edge outside reset
`define TTH_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define TTH_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// File: rtl/tth_pkg.sv
package tth_pkg;
    localparam int NUM_CHANNELS = 32;
    localparam int CH_W = $clog2(NUM_CHANNELS);
    localparam int REF_CH_A = 8;
    localparam int REF_CH_B = 9;

    localparam logic [1:0] CMD_HIT  = 2'd0;
    localparam logic [1:0] CMD_EOE  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;
    localparam logic [1:0] CMD_NOP  = 2'd3;

    localparam logic [2:0] REG_ACCEPT_LOW  = 3'd0;
    localparam logic [2:0] REG_ACCEPT_HIGH = 3'd1;
    localparam logic [2:0] REG_SPIKE       = 3'd2;
    localparam logic [2:0] REG_CUT_LOW     = 3'd3;
    localparam logic [2:0] REG_CUT_HIGH    = 3'd4;
    localparam logic [2:0] REG_MAX_LENGTH  = 3'd5;
    localparam logic [2:0] REG_KEEP_MODES  = 3'd6;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [5:0]        channel;
        logic              rising;
        logic signed [31:0] hit_time;
        logic [4:0]        counter_index;
    } t_in;

    typedef struct packed {
        logic              hit_done;
        logic signed [31:0] hit_length;
        logic              event_kept;
        logic [3:0]        layer_a_hits;
        logic [3:0]        layer_b_hits;
        logic [31:0]       ref_mask;
        logic [31:0]       dut_mask;
        logic [31:0]       ref_total;
        logic [31:0]       dut_total;
    } t_out;

    typedef struct packed {
        logic signed [31:0] accept_low;
        logic signed [31:0] accept_high;
        logic [30:0]        spike_threshold;
        logic signed [31:0] cut_low;
        logic signed [31:0] cut_high;
        logic [30:0]        max_length;
        logic [3:0]         keep_modes;
    } t_cfg;

    function automatic logic signed [31:0] sat_diff(logic signed [31:0] a,
                                                    logic signed [31:0] b);
        logic signed [32:0] d;
        d = 33'(a) - 33'(b);
        if (d > 33'sd2147483647)       sat_diff = 32'sh7fffffff;
        else if (d < -33'sd2147483648) sat_diff = 32'sh80000000;
        else                           sat_diff = d[31:0];
    endfunction
endpackage

// File: rtl/tth_cfg_regs.sv
module tth_cfg_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output tth_pkg::t_cfg      o_cfg
);
    import tth_pkg::*;
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accept_low      <= -32'sd475000;
            r_cfg.accept_high     <= 32'sd225000;
            r_cfg.spike_threshold <= 31'd60000;
            r_cfg.cut_low         <= -32'sd400000;
            r_cfg.cut_high        <= 32'sd300000;
            r_cfg.max_length      <= 31'd10000000;
            r_cfg.keep_modes      <= 4'd10;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ACCEPT_LOW:  r_cfg.accept_low      <= i_cfg_data;
                REG_ACCEPT_HIGH: r_cfg.accept_high     <= i_cfg_data;
                REG_SPIKE:       r_cfg.spike_threshold <= i_cfg_data[30:0];
                REG_CUT_LOW:     r_cfg.cut_low         <= i_cfg_data;
                REG_CUT_HIGH:    r_cfg.cut_high        <= i_cfg_data;
                REG_MAX_LENGTH:  r_cfg.max_length      <= i_cfg_data[30:0];
                REG_KEEP_MODES:  r_cfg.keep_modes      <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end
    assign o_cfg = r_cfg;
endmodule

// File: rtl/tdc_tot_hit_pairing_coincidence_unit.sv
// One command per start pulse, taken when busy is low; busy stays high until
// the result cycle is over. A hit message and a read each show their result
// after a memory read step and a compare and write back step, and the next
// command can be taken in the cycle after the result. End of event shows its
// result after the keep decision and the reference check when no reference
// hit is left; otherwise it walks every channel through the time and counter
// memories, one read and one compare per channel, with a partner read and
// compare added for each passing channel whose overlap partner holds a real
// hit. After reset the counter memories are cleared by a pass over all
// channels with busy high. Each result appears for one cycle with
// o_result_valid; the receiver cannot stall it.
module tdc_tot_hit_pairing_coincidence_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  tth_pkg::t_in        i_item,
    output logic                o_result_valid,
    output tth_pkg::t_out       o_result,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import tth_pkg::*;

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_HRD   = 11'b00000000100,
        S_HWR   = 11'b00000001000,
        S_RRD   = 11'b00000010000,
        S_EKEEP = 11'b00000100000,
        S_EREF  = 11'b00001000000,
        S_ECH   = 11'b00010000000,
        S_EOVA  = 11'b00100000000,
        S_EOVB  = 11'b01000000000,
        S_EFIN  = 11'b10000000000
    } t_state;

    t_cfg cfg;
    tth_cfg_regs u_cfg (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data, .o_cfg(cfg)
    );

    // per-channel stores: start candidate, start time, length, counters
    logic signed [31:0] m_cand  [NUM_CHANNELS];
    logic signed [31:0] m_start [NUM_CHANNELS];
    logic signed [31:0] m_len   [NUM_CHANNELS];
    logic [31:0]        m_ref   [NUM_CHANNELS];
    logic [31:0]        m_dut   [NUM_CHANNELS];

    t_state r_state;
    t_in    r_in;
    logic [NUM_CHANNELS-1:0] r_rise, r_fall, r_real;
    logic [CH_W-1:0] r_ch, r_ov;
    logic            r_wait;
    logic signed [31:0] r_tref, r_cand_q, r_start_q, r_len_q;
    logic [31:0] r_ref_q, r_dut_q, r_dut_hold;
    logic [31:0] r_rmask, r_dmask;
    logic [3:0]  r_na, r_nb;
    logic        r_keep, r_vld;
    t_out        r_out;

    logic [CH_W-1:0] rd_addr;
    logic [CH_W-1:0] ch_idx;
    logic [6:0]      chan_m1;
    logic            ch_ok, is_ref;
    logic signed [31:0] len;

    assign chan_m1 = {1'b0, r_in.channel} - 7'd1;
    assign ch_ok   = r_in.channel != 6'd0 && chan_m1 < 7'(NUM_CHANNELS);
    assign ch_idx  = chan_m1[CH_W-1:0];
    assign is_ref  = ch_idx == CH_W'(REF_CH_A) || ch_idx == CH_W'(REF_CH_B);
    assign len     = sat_diff(r_in.hit_time, r_cand_q);

    function automatic logic in_cut(logic signed [31:0] t, logic signed [31:0] ref_t,
                                    t_cfg c);
        logic signed [31:0] r;
        r = sat_diff(t, ref_t);
        in_cut = r > c.cut_low && r < c.cut_high;
    endfunction

    // layer counts
    logic [3:0] na, nb;
    logic [7:0] la_v, lb_v;
    logic       keep;
    always_comb begin
        la_v = r_real[7:0];
        lb_v = r_real[23:16];
        na = 4'($countones(la_v));
        nb = 4'($countones(lb_v));
        keep = 1'b0;
        if (cfg.keep_modes[2]) begin
            // two adjacent in layer a with one below in b, or the mirror
            for (int k = 0; k < 7; k++) begin
                if (na == 4'd2 && nb == 4'd1 && la_v[k] && la_v[k+1] && lb_v[k])
                    keep = 1'b1;
                if (na == 4'd1 && nb == 4'd2 && lb_v[k] && lb_v[k+1] && la_v[k+1])
                    keep = 1'b1;
            end
        end
        if (cfg.keep_modes[1] && na == 4'd1 && nb == 4'd1) keep = 1'b1;
        if (cfg.keep_modes[0] && ((na == 4'd0 && nb == 4'd1) || (na == 4'd1 && nb == 4'd0)))
            keep = 1'b1;
        if (!cfg.keep_modes[3]) keep = 1'b1;
    end

    // overlap partners of the current channel
    logic has_ov;
    logic [CH_W-1:0] ov_a, ov_b;
    always_comb begin
        has_ov = 1'b0;
        ov_a = '0;
        ov_b = '0;
        if (r_ch >= CH_W'(1) && r_ch <= CH_W'(7)) begin
            has_ov = 1'b1;
            ov_a = r_ch + CH_W'(15);
            ov_b = r_ch + CH_W'(16);
        end else if (r_ch >= CH_W'(16) && r_ch <= CH_W'(22)) begin
            has_ov = 1'b1;
            ov_a = r_ch - CH_W'(16);
            ov_b = r_ch - CH_W'(15);
        end
    end

    logic ch_pass, ch_eval;
    assign ch_pass = r_real[r_ch] && in_cut(r_start_q, r_tref, cfg)
                     && $signed(r_len_q) < $signed({1'b0, cfg.max_length});
    // read data of the current channel is valid in this cycle
    assign ch_eval = r_state == S_ECH && !r_keep && !r_wait;

    always_comb begin
        rd_addr = ch_idx;
        unique case (r_state)
            S_HRD:  rd_addr = ch_idx;
            S_RRD:  rd_addr = r_in.counter_index[CH_W-1:0];
            S_EREF: rd_addr = r_real[REF_CH_B] ? CH_W'(REF_CH_B) : CH_W'(REF_CH_A);
            S_EOVA, S_EOVB: rd_addr = r_ov;
            default: rd_addr = r_ch;
        endcase
    end

    // registered memory reads
    always_ff @(posedge i_clk) begin
        r_cand_q  <= m_cand[rd_addr];
        r_start_q <= m_start[rd_addr];
        r_len_q   <= m_len[rd_addr];
        r_ref_q   <= m_ref[rd_addr];
        r_dut_q   <= m_dut[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            m_ref[r_ch] <= '0;
            m_dut[r_ch] <= '0;
        end
        if (r_state == S_HRD && ch_ok && r_in.rising &&
            ((r_in.hit_time > cfg.accept_low && r_in.hit_time < cfg.accept_high) || is_ref))
            m_cand[ch_idx] <= r_in.hit_time;
        if (r_state == S_HWR && ch_ok && !r_in.rising && r_rise[ch_idx] &&
            !r_fall[ch_idx] && (len > $signed({1'b0, cfg.spike_threshold}) || is_ref)) begin
            m_start[ch_idx] <= r_cand_q;
            m_len[ch_idx]   <= len;
        end
        if (ch_eval && ch_pass && r_ref_q != 32'hffffffff)
            m_ref[r_ch] <= r_ref_q + 32'd1;
        if (r_state == S_EOVB && in_cut(r_start_q, r_tref, cfg) &&
            r_dut_hold != 32'hffffffff)
            m_dut[r_ch] <= r_dut_hold + 32'd1;
    end

    always_ff @(posedge i_clk) begin
        r_vld <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ch <= '0;
            r_rise <= '0;
            r_fall <= '0;
            r_real <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_ch <= r_ch + CH_W'(1);
                    if (r_ch == CH_W'(NUM_CHANNELS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (start && !r_vld) begin
                    r_in <= i_item;
                    r_out <= '0;
                    case (i_item.cmd)
                        CMD_HIT:  r_state <= S_HRD;
                        CMD_EOE:  r_state <= S_EKEEP;
                        CMD_READ: r_state <= S_RRD;
                        default:  r_state <= S_IDLE;
                    endcase
                end
                S_HRD: begin
                    r_state <= S_HWR;
                    if (ch_ok && r_in.rising &&
                        ((r_in.hit_time > cfg.accept_low && r_in.hit_time < cfg.accept_high)
                         || is_ref)) begin
                        r_rise[ch_idx] <= 1'b1;
                        r_fall[ch_idx] <= 1'b0;
                    end
                end
                S_HWR: begin
                    if (ch_ok && !r_in.rising && r_rise[ch_idx] && !r_fall[ch_idx]) begin
                        r_fall[ch_idx] <= 1'b1;
                        if (len > $signed({1'b0, cfg.spike_threshold}) || is_ref) begin
                            r_real[ch_idx] <= 1'b1;
                            r_out.hit_done <= 1'b1;
                            r_out.hit_length <= len;
                        end
                    end
                    r_vld <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_RRD: begin
                    // the read is issued this cycle; the output register takes the data in S_EFIN
                    r_state <= S_EFIN;
                    r_ch <= '0;
                    r_keep <= 1'b0;
                end
                S_EKEEP: begin
                    r_na <= na;
                    r_nb <= nb;
                    r_keep <= 1'b1;
                    r_out.event_kept <= keep;
                    r_rmask <= '0;
                    r_dmask <= '0;
                    if (!keep) r_real <= '0;
                    r_state <= S_EREF;
                end
                S_EREF: begin
                    r_ch <= '0;
                    r_wait <= 1'b0;
                    if (!(r_real[REF_CH_A] || r_real[REF_CH_B])) r_state <= S_EFIN;
                    else r_state <= S_ECH;
                end
                S_ECH: begin
                    if (r_keep) begin
                        // reference start time lands first
                        r_tref <= r_start_q;
                        r_keep <= 1'b0;
                    end else if (r_wait) begin
                        r_wait <= 1'b0;
                    end else begin
                        if (ch_pass) r_rmask[r_ch] <= 1'b1;
                        r_dut_hold <= r_dut_q;
                        if (ch_pass && has_ov && (r_real[ov_a] || r_real[ov_b])) begin
                            r_ov <= r_real[ov_a] ? ov_a : ov_b;
                            r_state <= S_EOVA;
                        end else if (r_ch == CH_W'(NUM_CHANNELS - 1)) begin
                            r_state <= S_EFIN;
                        end else begin
                            r_ch <= r_ch + CH_W'(1);
                            r_wait <= 1'b1;
                        end
                    end
                end
                S_EOVA: begin
                    r_state <= S_EOVB;
                end
                S_EOVB: begin
                    // partner start time is valid here
                    if (in_cut(r_start_q, r_tref, cfg)) r_dmask[r_ch] <= 1'b1;
                    if (r_ch == CH_W'(NUM_CHANNELS - 1)) begin
                        r_state <= S_EFIN;
                    end else begin
                        r_ch <= r_ch + CH_W'(1);
                        r_wait <= 1'b1;
                        r_state <= S_ECH;
                    end
                end
                S_EFIN: begin
                    if (r_in.cmd == CMD_READ) begin
                        if ({1'b0, r_in.counter_index} < 6'(NUM_CHANNELS)) begin
                            r_out.ref_total <= r_ref_q;
                            r_out.dut_total <= r_dut_q;
                        end
                        r_vld <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_IDLE;
                        r_out.layer_a_hits <= r_na;
                        r_out.layer_b_hits <= r_nb;
                        r_out.ref_mask <= r_rmask;
                        r_out.dut_mask <= r_dmask;
                        r_vld <= 1'b1;
                        r_rise <= '0;
                        r_fall <= '0;
                        r_real <= '0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy = r_state != S_IDLE || r_vld;
    assign o_result_valid = r_vld;
    assign o_result = r_out;
endmodule

// File: rtl/tth_checker.sv
`include "tdc_tot_hit_pairing_coincidence_unit_defines.svh"
module tth_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_result_valid,
    input tth_pkg::t_out o_result
);
    import tth_pkg::*;
    `TTH_ASSERT_IMP(a_vld_busy, i_clk, i_rst_n, o_result_valid, busy)
    `TTH_ASSERT_NXT(a_one_cycle, i_clk, i_rst_n, o_result_valid, !o_result_valid)
    `TTH_ASSERT_IMP(a_done_len, i_clk, i_rst_n, o_result_valid && !o_result.hit_done,
        o_result.hit_length == 32'sd0)
    `TTH_ASSERT_IMP(a_counts, i_clk, i_rst_n, o_result_valid,
        o_result.layer_a_hits <= 4'd8 && o_result.layer_b_hits <= 4'd8)
endmodule

bind tdc_tot_hit_pairing_coincidence_unit tth_checker u_chk (
    .i_clk, .i_rst_n, .start, .busy, .o_result_valid, .o_result
);

// File: verif/tdc_tot_hit_pairing_coincidence_unit_checker.sv
`timescale 1ns / 1ps
module tdc_tot_hit_pairing_coincidence_unit_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  logic           busy,
    input  tth_pkg::t_in   i_item,
    input  logic           o_result_valid,
    input  tth_pkg::t_out  o_result,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_data,
    output int             o_fail_count,
    output int             o_pending,
    output int             o_hits_built,
    output int             o_events_kept
);
    import tth_pkg::*;

    t_cfg cfg;
    logic                rise_seen [NUM_CHANNELS];
    logic                fall_seen [NUM_CHANNELS];
    logic                real_hit  [NUM_CHANNELS];
    logic signed [31:0]  start_cand [NUM_CHANNELS];
    logic signed [31:0]  start_t [NUM_CHANNELS];
    logic signed [31:0]  len_st [NUM_CHANNELS];
    logic [31:0]         ref_cnt [NUM_CHANNELS];
    logic [31:0]         dut_cnt [NUM_CHANNELS];
    t_out                expected_beats [$];

    function automatic logic signed [31:0] diff_sat(logic signed [31:0] a,
                                                    logic signed [31:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d > 64'sd2147483647) d = 64'sd2147483647;
        if (d < -64'sd2147483648) d = -64'sd2147483648;
        return d[31:0];
    endfunction

    function automatic bit cut_ok(logic signed [31:0] t, logic signed [31:0] tref);
        logic signed [31:0] r;
        r = diff_sat(t, tref);
        return r > cfg.cut_low && r < cfg.cut_high;
    endfunction

    function automatic bit real_at(int ch);
        return ch >= 0 && ch < NUM_CHANNELS && real_hit[ch];
    endfunction

    task automatic clear_event();
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            rise_seen[i] = 0;
            fall_seen[i] = 0;
            real_hit[i] = 0;
        end
    endtask

    task automatic predict_hit(t_in it, inout t_out r);
        int c;
        bit is_ref;
        logic signed [31:0] len;
        if (it.channel == 0 || it.channel - 1 >= NUM_CHANNELS) return;
        c = it.channel - 1;
        is_ref = (c == REF_CH_A || c == REF_CH_B);
        if (it.rising) begin
            if ((it.hit_time > cfg.accept_low && it.hit_time < cfg.accept_high) || is_ref) begin
                rise_seen[c] = 1;
                fall_seen[c] = 0;
                start_cand[c] = it.hit_time;
            end
        end else if (rise_seen[c] && !fall_seen[c]) begin
            len = diff_sat(it.hit_time, start_cand[c]);
            fall_seen[c] = 1;
            if (longint'(len) > longint'(cfg.spike_threshold) || is_ref) begin
                start_t[c] = start_cand[c];
                len_st[c] = len;
                real_hit[c] = 1;
                r.hit_done = 1;
                r.hit_length = len;
            end
        end
    endtask

    task automatic predict_event(inout t_out r);
        int la[$], lb[$];
        bit keep;
        bit rose;
        int da, db;
        logic signed [31:0] tref;
        keep = 0;
        for (int i = 0; i < 8; i++) if (real_hit[i]) la.push_back(i);
        for (int i = 16; i < 24; i++) if (real_hit[i]) lb.push_back(i);
        if (cfg.keep_modes[2]) begin
            if (la.size() == 2 && lb.size() == 1 && la[0] == la[1] - 1 && la[0] == lb[0] - 16)
                keep = 1;
            if (la.size() == 1 && lb.size() == 2 && lb[0] == lb[1] - 1 && la[0] == lb[0] - 15)
                keep = 1;
        end
        if (cfg.keep_modes[1] && la.size() == 1 && lb.size() == 1) keep = 1;
        if (cfg.keep_modes[0] && la.size() + lb.size() == 1) keep = 1;
        if (!cfg.keep_modes[3]) keep = 1;
        r.layer_a_hits = 4'(la.size());
        r.layer_b_hits = 4'(lb.size());
        if (!keep) for (int i = 0; i < NUM_CHANNELS; i++) real_hit[i] = 0;
        if (real_hit[REF_CH_A] || real_hit[REF_CH_B]) begin
            tref = real_hit[REF_CH_B] ? start_t[REF_CH_B] : start_t[REF_CH_A];
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                if (!real_hit[i] || !cut_ok(start_t[i], tref)
                    || !(longint'(len_st[i]) < longint'(cfg.max_length)))
                    continue;
                if (ref_cnt[i] != '1) ref_cnt[i]++;
                if (i < 32) r.ref_mask[i] = 1;
                if (i >= 1 && i <= 7) begin
                    da = i + 15; db = i + 16;
                end else if (i >= 16 && i <= 22) begin
                    da = i - 16; db = i - 15;
                end else continue;
                rose = 0;
                if (real_at(da)) rose = cut_ok(start_t[da], tref);
                else if (real_at(db)) rose = cut_ok(start_t[db], tref);
                if (rose) begin
                    if (dut_cnt[i] != '1) dut_cnt[i]++;
                    if (i < 32) r.dut_mask[i] = 1;
                end
            end
        end
        r.event_kept = keep;
        if (keep) o_events_kept++;
        clear_event();
    endtask

    always @(posedge i_clk) begin
        t_out r;
        t_out e;
        if (!i_rst_n) begin
            cfg.accept_low = -32'sd475000;
            cfg.accept_high = 32'sd225000;
            cfg.spike_threshold = 31'd60000;
            cfg.cut_low = -32'sd400000;
            cfg.cut_high = 32'sd300000;
            cfg.max_length = 31'd10000000;
            cfg.keep_modes = 4'd10;
            clear_event();
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                ref_cnt[i] = 0;
                dut_cnt[i] = 0;
            end
            expected_beats.delete();
            o_fail_count = 0;
            o_hits_built = 0;
            o_events_kept = 0;
        end else begin
            // result beats are checked before the new command's prediction
            if (o_result_valid) begin
                if (expected_beats.size() == 0) begin
                    $display("%0t: unexpected result beat %p", $time, o_result);
                    o_fail_count++;
                end else begin
                    e = expected_beats.pop_front();
                    if (o_result !== e) begin
                        $display("%0t: mismatch expected %p actual %p", $time, e, o_result);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ACCEPT_LOW:  cfg.accept_low = i_cfg_data;
                    REG_ACCEPT_HIGH: cfg.accept_high = i_cfg_data;
                    REG_SPIKE:       cfg.spike_threshold = i_cfg_data[30:0];
                    REG_CUT_LOW:     cfg.cut_low = i_cfg_data;
                    REG_CUT_HIGH:    cfg.cut_high = i_cfg_data;
                    REG_MAX_LENGTH:  cfg.max_length = i_cfg_data[30:0];
                    REG_KEEP_MODES:  cfg.keep_modes = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (start && !busy && i_item.cmd != CMD_NOP) begin
                r = '0;
                case (i_item.cmd)
                    CMD_HIT: begin
                        predict_hit(i_item, r);
                        if (r.hit_done) o_hits_built++;
                    end
                    CMD_EOE: predict_event(r);
                    default: begin
                        if (i_item.counter_index < NUM_CHANNELS) begin
                            r.ref_total = ref_cnt[i_item.counter_index];
                            r.dut_total = dut_cnt[i_item.counter_index];
                        end
                    end
                endcase
                expected_beats.push_back(r);
            end
        end
        o_pending = expected_beats.size();
    end
endmodule

// File: verif/tdc_tot_hit_pairing_coincidence_unit_test.sv
`timescale 1ns / 1ps
module tdc_tot_hit_pairing_coincidence_unit_test;
    import tth_pkg::*;

    localparam int WATCHDOG = 20000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic start = 0;
    logic busy;
    t_in  i_item = '0;
    logic o_result_valid;
    t_out o_result;
    logic i_cfg_we = 0;
    logic [2:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    int fail_count, pending, hits_built, events_kept;
    int idle_pct;
    int items_sent;
    int quiet_cycles;
    bit timed_out;

    always #5 i_clk = ~i_clk;

    tdc_tot_hit_pairing_coincidence_unit u_top (.*);

    tdc_tot_hit_pairing_coincidence_unit_checker u_check (
        .i_clk, .i_rst_n, .start, .busy, .i_item, .o_result_valid, .o_result,
        .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending),
        .o_hits_built(hits_built), .o_events_kept(events_kept)
    );

    // watchdog: cycles without any accepted command or result beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG && !timed_out) begin
            timed_out = 1;
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send(t_in it);
        while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        start <= 1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        start <= 0;
        @(posedge i_clk);
        items_sent++;
    endtask

    function automatic t_in hit_beat(int ch, bit rise, logic signed [31:0] t);
        t_in it;
        it = '0;
        it.cmd = CMD_HIT;
        it.channel = 6'(ch);
        it.rising = rise;
        it.hit_time = t;
        it.counter_index = 5'($urandom);
        return it;
    endfunction

    function automatic t_in cmd_beat(logic [1:0] cmd, int idx);
        t_in it;
        it = '0;
        it.cmd = cmd;
        it.counter_index = 5'(idx);
        it.channel = 6'($urandom);
        it.rising = 1'($urandom);
        it.hit_time = $urandom;
        return it;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        int n;
        n = 0;
        while (pending != 0 && n < WATCHDOG) begin
            @(posedge i_clk);
            n++;
        end
        repeat (3 * NUM_CHANNELS + 20) @(posedge i_clk);
    endtask

    // one hit on channel index c (0-based), start time t, length len
    task automatic pulse(int c, int t, int len);
        send(hit_beat(c + 1, 1, t));
        send(hit_beat(c + 1, 0, t + len));
    endtask

    task automatic random_event();
        int n;
        int c;
        int t;
        int tref;
        tref = $urandom_range(0, 40000) - 20000;
        if ($urandom_range(9) < 8) pulse($urandom_range(REF_CH_A, REF_CH_B), tref,
                                          $urandom_range(1000, 200000));
        n = $urandom_range(0, 5);
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(9))
                0, 1, 2, 3: c = $urandom_range(0, 7);
                4, 5, 6, 7: c = $urandom_range(16, 23);
                default: c = $urandom_range(0, 31);
            endcase
            t = tref + $urandom_range(0, 500000) - 250000;
            if ($urandom_range(9) == 0) t = $urandom;
            pulse(c, t, $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 300000));
        end
        // noise: stray edges, trigger channel, out of range, no-op command, stray read
        n = $urandom_range(0, 2);
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(3))
                0: send(hit_beat($urandom_range(0, 63), 1'($urandom), $urandom));
                1: send(hit_beat($urandom_range(1, 32), 0, $urandom));
                2: send(cmd_beat(CMD_NOP, $urandom));
                default: send(cmd_beat(CMD_READ, $urandom));
            endcase
        end
        send(cmd_beat(CMD_EOE, 0));
        if ($urandom_range(3) == 0) send(cmd_beat(CMD_READ, $urandom_range(0, 31)));
    endtask

    task automatic random_config(int mode);
        write_reg(REG_ACCEPT_LOW, mode == 0 ? 32'h8000_0000 : -475000);
        write_reg(REG_ACCEPT_HIGH, mode == 0 ? 32'h7fff_ffff : 225000);
        write_reg(REG_SPIKE, mode == 0 ? 0 : (mode == 1 ? 32'h7fff_ffff : $urandom_range(0, 80000)));
        write_reg(REG_CUT_LOW, mode == 0 ? 32'h8000_0000 : -400000);
        write_reg(REG_CUT_HIGH, mode == 0 ? 32'h7fff_ffff : 300000);
        write_reg(REG_MAX_LENGTH, mode == 0 ? 32'h7fff_ffff : (mode == 1 ? 0 : 10000000));
        write_reg(REG_KEEP_MODES, mode == 0 ? 0 : (mode == 1 ? 15 : $urandom_range(0, 15)));
    endtask

    initial begin
        int phase_pct[4];
        phase_pct = '{0, 69, 0, 7};
        idle_pct = 0;
        items_sent = 0;
        timed_out = 0;
        quiet_cycles = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        drain();

        // directed: extremes, reference channels, keep rules, specials
        send(hit_beat(0, 1, 0));
        send(hit_beat(33, 1, 0));
        send(hit_beat(63, 0, 32'h7fff_ffff));
        send(hit_beat(2, 0, 100));
        pulse(REF_CH_B, 32'h8000_0000, 32'h7fff_ffff);
        pulse(REF_CH_A, 0, 10);
        pulse(2, 1000, 100000);
        send(hit_beat(3, 0, 500000));
        pulse(18, 2000, 90000);
        pulse(3, -474999, 70000);
        send(hit_beat(5, 1, 224999));
        send(hit_beat(5, 1, 225000));
        send(hit_beat(6, 1, -475000));
        pulse(4, 0, 60000);
        send(cmd_beat(CMD_EOE, 0));
        send(cmd_beat(CMD_READ, 1));
        send(cmd_beat(CMD_READ, 17));
        send(cmd_beat(CMD_READ, 31));
        send(cmd_beat(CMD_NOP, 0));
        send(cmd_beat(CMD_EOE, 0));
        drain();

        for (int p = 0; p < 8; p++) begin
            idle_pct = phase_pct[p % 4];
            random_config(p < 3 ? p : 2 + $urandom_range(0, 1));
            while (items_sent < 110 * (p + 1) - 30) random_event();
            drain();
        end

        $display("covered %0d commands, %0d hits built, %0d events kept over 8 settings",
                 items_sent, hits_built, events_kept);
        if (fail_count == 0 && pending == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// File: tdc_tot_hit_pairing_coincidence_unit.f
+incdir+rtl
rtl/tth_pkg.sv
rtl/tth_cfg_regs.sv
rtl/tdc_tot_hit_pairing_coincidence_unit.sv
rtl/tth_checker.sv
verif/tdc_tot_hit_pairing_coincidence_unit_checker.sv
verif/tdc_tot_hit_pairing_coincidence_unit_test.sv
